FILE: hdl/assert_macros.svh
// Assertion macros used by the port-level checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is high.
`define CHK_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Delayed implication: the consequent is checked later than the antecedent.
`define CHK_AFTER2(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> ##1 (cons)) \
    else $error("delayed implication check failed");

// Condition that must hold at every edge outside reset.
`define CHK_ALWAYS(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("invariant check failed");

`endif

FILE: hdl/wchf_pkg.sv
// Package: request/result types and opcode constants for the hazard filter.
`timescale 1ns / 1ps

package wchf_pkg;

  // Request kinds
  localparam logic [1:0] KIND_PUSH    = 2'd0;
  localparam logic [1:0] KIND_POP     = 2'd1;
  localparam logic [1:0] KIND_COMPARE = 2'd2;

  // Request opcodes that matter to the match
  localparam logic [3:0] OP_SET    = 4'd1;
  localparam logic [3:0] OP_DELETE = 4'd4;
  localparam logic [3:0] OP_FLUSH  = 4'd8;

  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned OP_W    = 4;
  localparam int unsigned LEVEL_W = 7;

  typedef struct packed {
    logic [1:0]        kind;
    logic [ADDR_W-1:0] address;
    logic [OP_W-1:0]   operation;
    logic              entry_valid;
  } req_t;

  typedef struct packed {
    logic               done_res;
    logic               hazard;
    logic               is_full;
    logic [LEVEL_W-1:0] fill_level;
    logic               underflow;
  } rsp_t;

endpackage

FILE: hdl/write_conflict_hazard_filter_core.sv
// Top level: circular queue of in-flight requests with a parallel hazard match.
//
//  channel   | ports                 | transfer when
//  ----------+-----------------------+-------------------------------
//  request   | start, busy, req      | start high and busy low at clk
//  result    | done, result          | done high at clk (one cycle)
//
// One request is taken every cycle; busy never rises.
// A result passes the input register, then match/update logic into the
// result register.
// The 32-bit compare per slot and the OR over all slots set the stage depth.
// rst (synchronous) clears the valid marks, pointers, level and strobes.
// The result side cannot stall; each result is shown for exactly one cycle.
`timescale 1ns / 1ps

module write_conflict_hazard_filter_core
  import wchf_pkg::*;
#(
  parameter int unsigned ENTRIES = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t req,
  output logic done,
  output rsp_t result
);

  localparam int unsigned PTR_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned OCC_W = $clog2(ENTRIES + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(ENTRIES - 1);
  localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(ENTRIES);

  // Input register
  logic in_valid;
  req_t in_req;

  // Queue state
  logic [ADDR_W-1:0]  slot_address   [ENTRIES];
  logic [OP_W-1:0]    slot_operation [ENTRIES];
  logic [ENTRIES-1:0] slot_valid;
  logic [PTR_W-1:0]   write_pointer;
  logic [PTR_W-1:0]   read_pointer;
  logic [OCC_W-1:0]   occupancy;

  logic [OCC_W-1:0]   occupancy_next;
  logic [ENTRIES-1:0] slot_hit;
  logic               push_ok;
  logic               pop_ok;
  logic               pop_empty;
  logic               is_compare;
  rsp_t               result_next;

  assign busy = 1'b0;

  // Capture the request
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start & ~busy;
    end
    in_req <= req;
  end

  // Decode the registered request against the queue state
  always_comb begin
    push_ok    = (in_req.kind == KIND_PUSH) && (occupancy != OCC_FULL);
    pop_ok     = (in_req.kind == KIND_POP) && (occupancy != '0);
    pop_empty  = (in_req.kind == KIND_POP) && (occupancy == '0);
    is_compare = (in_req.kind == KIND_COMPARE);
  end

  // Parallel match over every slot
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      slot_hit[i] = slot_valid[i] &&
                    ((slot_operation[i] == OP_FLUSH) ||
                     ((slot_address[i] == in_req.address) &&
                      ((slot_operation[i] == OP_SET) ||
                       (slot_operation[i] == OP_DELETE))));
    end
  end

  // Level after this step and the result word
  always_comb begin
    occupancy_next = occupancy;
    if (push_ok) begin
      occupancy_next = occupancy + OCC_W'(1);
    end else if (pop_ok) begin
      occupancy_next = occupancy - OCC_W'(1);
    end
    result_next.done_res   = push_ok | pop_ok | is_compare;
    result_next.hazard     = is_compare & (|slot_hit);
    result_next.is_full    = (occupancy_next == OCC_FULL);
    result_next.fill_level = LEVEL_W'(occupancy_next);
    result_next.underflow  = pop_empty;
  end

  // Control state: pointers, level, valid marks
  always_ff @(posedge clk) begin
    if (rst) begin
      write_pointer <= '0;
      read_pointer  <= '0;
      occupancy     <= '0;
      slot_valid    <= '0;
    end else if (in_valid) begin
      occupancy <= occupancy_next;
      if (push_ok) begin
        slot_valid[write_pointer] <= in_req.entry_valid;
        write_pointer <= (write_pointer == PTR_LAST) ? '0 : write_pointer + PTR_W'(1);
      end else if (pop_ok) begin
        slot_valid[read_pointer] <= 1'b0;
        read_pointer <= (read_pointer == PTR_LAST) ? '0 : read_pointer + PTR_W'(1);
      end
    end
  end

  // Slot payload; only read where the valid mark is set
  always_ff @(posedge clk) begin
    if (in_valid && push_ok) begin
      slot_address[write_pointer]   <= in_req.address;
      slot_operation[write_pointer] <= in_req.operation;
    end else if (in_valid && pop_ok) begin
      slot_address[read_pointer] <= '0;
    end
  end

  // Result register and strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
    result <= result_next;
  end

endmodule

FILE: hdl/wchf_checker.sv
// Checker: port-level properties of the hazard filter, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wchf_checker
  import wchf_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input rsp_t result
);

  // Every accepted request later yields a result strobe
  `CHK_AFTER2(a_result_follows, clk, rst, start && !busy, done)

  // A hazard is only reported by a compare, which always completes
  `CHK_IMPLY(a_hazard_done, clk, rst, done && result.hazard, result.done_res)

  // An ignored pop leaves an empty queue and reports nothing else
  `CHK_IMPLY(a_underflow_empty, clk, rst, done && result.underflow, (result.fill_level == '0) && !result.done_res && !result.hazard)

  // A full queue cannot have level zero
  `CHK_IMPLY(a_full_level, clk, rst, done && result.is_full, result.fill_level != '0)

  // Requests are never held off
  `CHK_ALWAYS(a_never_busy, clk, rst, !busy)

endmodule

bind write_conflict_hazard_filter_core wchf_checker u_wchf_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

FILE: sim/hazard_filter_checker.sv
// Checker: predicts hazard filter results from observed request transfers and compares them.
`timescale 1ns / 1ps

module hazard_filter_checker
  import wchf_pkg::*;
#(
  parameter int unsigned ENTRIES = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic busy,
  input  req_t req,
  input  logic done,
  input  rsp_t result,
  output int   fail_count,
  output int   pending
);

  // Shadow copy of the request queue
  logic [ADDR_W-1:0] slot_addr [ENTRIES];
  logic [OP_W-1:0]   slot_op   [ENTRIES];
  logic              slot_vld  [ENTRIES];
  int unsigned       wr_ptr;
  int unsigned       rd_ptr;
  int unsigned       level;

  rsp_t expected_rsp_q [$];
  int   errs = 0;

  // Apply one request to the shadow queue and return the result it should produce
  function automatic rsp_t predict_filter_response(req_t r);
    rsp_t rsp;
    rsp = '0;
    case (r.kind)
      KIND_PUSH: begin
        if (level < ENTRIES) begin
          slot_addr[wr_ptr] = r.address;
          slot_op[wr_ptr]   = r.operation;
          slot_vld[wr_ptr]  = r.entry_valid;
          wr_ptr = (wr_ptr == ENTRIES - 1) ? 0 : wr_ptr + 1;
          level++;
          rsp.done_res = 1'b1;
        end
      end
      KIND_POP: begin
        if (level == 0) begin
          rsp.underflow = 1'b1;
        end else begin
          // opcode of the retired slot is kept, address and valid mark cleared
          slot_addr[rd_ptr] = '0;
          slot_vld[rd_ptr]  = 1'b0;
          rd_ptr = (rd_ptr == ENTRIES - 1) ? 0 : rd_ptr + 1;
          level--;
          rsp.done_res = 1'b1;
        end
      end
      KIND_COMPARE: begin
        rsp.done_res = 1'b1;
        for (int i = 0; i < ENTRIES; i++) begin
          if (slot_vld[i]) begin
            // a valid flush blocks everything
            if (slot_op[i] == OP_FLUSH) rsp.hazard = 1'b1;
            if (slot_addr[i] == r.address && (slot_op[i] == OP_SET || slot_op[i] == OP_DELETE))
              rsp.hazard = 1'b1;
          end
        end
      end
      default: ;
    endcase
    rsp.is_full    = (level == ENTRIES);
    rsp.fill_level = level[LEVEL_W-1:0];
    return rsp;
  endfunction

  function automatic void check_field(string name, logic [LEVEL_W-1:0] exp_v,
                                      logic [LEVEL_W-1:0] got_v);
    if (got_v !== exp_v) begin
      errs++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
    end
  endfunction

  // Predict on each request transfer, compare on each result strobe
  always @(posedge clk) begin
    rsp_t exp_rsp;
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) begin
        slot_addr[i] = '0;
        slot_op[i]   = '0;
        slot_vld[i]  = 1'b0;
      end
      wr_ptr = 0;
      rd_ptr = 0;
      level  = 0;
      expected_rsp_q.delete();
    end else begin
      if (start && !busy) expected_rsp_q.push_back(predict_filter_response(req));
      if (done) begin
        if (expected_rsp_q.size() == 0) begin
          errs++;
          $display("%0t: unexpected result, expected none, got %p", $time, result);
        end else begin
          exp_rsp = expected_rsp_q.pop_front();
          check_field("done_res", LEVEL_W'(exp_rsp.done_res), LEVEL_W'(result.done_res));
          check_field("hazard", LEVEL_W'(exp_rsp.hazard), LEVEL_W'(result.hazard));
          check_field("is_full", LEVEL_W'(exp_rsp.is_full), LEVEL_W'(result.is_full));
          check_field("fill_level", exp_rsp.fill_level, result.fill_level);
          check_field("underflow", LEVEL_W'(exp_rsp.underflow), LEVEL_W'(result.underflow));
        end
      end
    end
    pending    <= expected_rsp_q.size();
    fail_count <= errs;
  end

endmodule

FILE: sim/tb_top.sv
// Testbench top: reset, clock, request stimulus, watchdog and final verdict.
`timescale 1ns / 1ps

module tb_top;
  import wchf_pkg::*;

  localparam int unsigned ENTRIES      = 8;
  localparam logic [1:0]  KIND_NONE    = 2'd3;
  localparam logic [3:0]  OP_GET       = 4'd0;
  localparam int          STALL_LIMIT  = 1000;
  localparam int          RANDOM_ITEMS = 1740;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic done;
  req_t req;
  rsp_t result;

  int fail_count;
  int pending;
  int stall_cycles = 0;
  int unsigned idle_pct;
  logic [ADDR_W-1:0] addr_pool [16];

  write_conflict_hazard_filter_core #(.ENTRIES(ENTRIES)) dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .req    (req),
    .done   (done),
    .result (result)
  );

  hazard_filter_checker #(.ENTRIES(ENTRIES)) u_check (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .req        (req),
    .done       (done),
    .result     (result),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: cycles with neither a request nor a result transfer
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic req_t make_req(logic [1:0] kind, logic [ADDR_W-1:0] addr,
                                    logic [OP_W-1:0] op, logic vld);
    req_t r;
    r.kind        = kind;
    r.address     = addr;
    r.operation   = op;
    r.entry_valid = vld;
    return r;
  endfunction

  // Random request; mode 0 fills, 1 drains, 2 keeps the level even
  function automatic req_t shaped_request(int unsigned mode);
    req_t r;
    int unsigned pick;
    int unsigned w_push;
    int unsigned w_pop;
    w_push = (mode == 0) ? 55 : (mode == 1) ? 15 : 30;
    w_pop  = (mode == 0) ? 15 : (mode == 1) ? 55 : 30;
    pick = $urandom_range(99);
    if (pick < 3) r.kind = KIND_NONE;
    else if (pick < 3 + w_push) r.kind = KIND_PUSH;
    else if (pick < 3 + w_push + w_pop) r.kind = KIND_POP;
    else r.kind = KIND_COMPARE;
    // mostly pool addresses so compares hit stored entries
    r.address = ($urandom_range(3) != 0) ? addr_pool[$urandom_range(15)] : $urandom;
    pick = $urandom_range(99);
    if (pick < 30) r.operation = OP_SET;
    else if (pick < 55) r.operation = OP_DELETE;
    else if (pick < 75) r.operation = OP_GET;
    else if (pick < 83) r.operation = OP_FLUSH;
    else r.operation = 4'($urandom_range(15));
    r.entry_valid = ($urandom_range(99) < 85);
    return r;
  endfunction

  // One request transfer, preceded by random idle cycles
  task automatic send_request(input req_t item);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      req   <= shaped_request($urandom_range(2));
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    start <= 1'b1;
    req   <= item;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Hold the sender off until every expected result has arrived
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int unsigned mode;
    start    = 1'b0;
    req      = '0;
    rst      = 1'b1;
    idle_pct = 0;
    mode     = 2;
    addr_pool[0] = '0;
    addr_pool[1] = '1;
    for (int i = 2; i < 16; i++) addr_pool[i] = $urandom;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty queue corner cases
    send_request(make_req(KIND_POP, 32'h0, OP_GET, 1'b0));
    send_request(make_req(KIND_COMPARE, 32'h0, OP_SET, 1'b1));
    send_request(make_req(KIND_NONE, 32'hFFFF_FFFF, 4'hF, 1'b1));
    // Address extremes with SET and delete
    send_request(make_req(KIND_PUSH, 32'hFFFF_FFFF, OP_SET, 1'b1));
    send_request(make_req(KIND_COMPARE, 32'hFFFF_FFFF, OP_GET, 1'b0));
    send_request(make_req(KIND_COMPARE, 32'h0, OP_GET, 1'b0));
    send_request(make_req(KIND_PUSH, 32'h0, OP_DELETE, 1'b1));
    send_request(make_req(KIND_COMPARE, 32'h0, 4'hF, 1'b1));
    // Entry pushed without valid mark never matches; GET never matches
    send_request(make_req(KIND_PUSH, 32'h1234_5678, OP_SET, 1'b0));
    send_request(make_req(KIND_PUSH, 32'hA5A5_A5A5, OP_GET, 1'b1));
    send_request(make_req(KIND_COMPARE, 32'h1234_5678, OP_SET, 1'b1));
    send_request(make_req(KIND_COMPARE, 32'hA5A5_A5A5, OP_SET, 1'b1));
    // Unlisted opcode, then a flush that matches any address
    send_request(make_req(KIND_PUSH, 32'h5A5A_5A5A, 4'hF, 1'b1));
    send_request(make_req(KIND_PUSH, 32'h0000_FFFF, OP_FLUSH, 1'b1));
    send_request(make_req(KIND_COMPARE, 32'hFFFF_0000, OP_GET, 1'b0));
    // Fill up, push while full, undefined kind while full
    send_request(make_req(KIND_PUSH, 32'h8000_0001, OP_SET, 1'b1));
    send_request(make_req(KIND_PUSH, 32'h7FFF_FFFE, OP_DELETE, 1'b1));
    send_request(make_req(KIND_PUSH, 32'hDEAD_0000, OP_SET, 1'b1));
    send_request(make_req(KIND_COMPARE, 32'hDEAD_0000, OP_GET, 1'b0));
    send_request(make_req(KIND_NONE, 32'h0, OP_GET, 1'b0));
    // Drain everything and pop once more on empty
    for (int i = 0; i < ENTRIES + 1; i++)
      send_request(make_req(KIND_POP, $urandom, 4'($urandom_range(15)), 1'($urandom_range(1))));
    drain_results();

    // Random phases: no sender idling, heavy idling, moderate idling
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 0 : (ph == 1) ? 54 : 33;
      for (int n = 0; n < RANDOM_ITEMS / 3; n++) begin
        if (n % 40 == 0) mode = $urandom_range(2);
        send_request(shaped_request(mode));
      end
      drain_results();
    end

    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
